@@ hw/rtl/assert_macros.svh @@
// assertion macros for the rtl files
// no dependencies; included by modules that carry checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define AFFRA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("affra check failed");

// next-cycle implication, checked out of reset
`define AFFRA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("affra check failed");

`endif

@@ hw/rtl/affra_pkg.sv @@
// types and constants of the aligned first-fit range allocator
// no dependencies; used by affra_cell and the top level
package affra_pkg;

    localparam int AW = 32;
    localparam int SW = 33;
    localparam int LW = 5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef logic [3:0] cell_op_t;

    localparam cell_op_t OP_HOLD       = 4'd0;
    localparam cell_op_t OP_INIT       = 4'd1;
    localparam cell_op_t OP_TAKE_RIGHT = 4'd2;
    localparam cell_op_t OP_TAKE_LEFT  = 4'd3;
    localparam cell_op_t OP_SHRINK     = 4'd4;
    localparam cell_op_t OP_SET_START  = 4'd5;
    localparam cell_op_t OP_SET_END    = 4'd6;
    localparam cell_op_t OP_HI_RIGHT   = 4'd7;
    localparam cell_op_t OP_LOAD       = 4'd8;

    typedef struct packed {
        logic          valid;
        logic [AW-1:0] lo;
        logic [AW-1:0] hi;
    } seg_t;

    typedef struct packed {
        logic          do_align;
        logic          do_eval;
        logic [AW-1:0] amask;
        logic [SW-1:0] size_m1;
        logic [AW-1:0] fs;
        logic [AW-1:0] fe;
        logic [AW-1:0] last;
    } cell_bcast_t;

    typedef struct packed {
        logic fit;
        logic exact;
        logic below;
        logic overlap;
        logic prev_match;
        logic next_match;
    } cell_flags_t;

endpackage

@@ hw/rtl/affra_cell.sv @@
// one free-segment cell of the allocator chain
// depends on affra_pkg; a cell takes a neighbor's segment on a shift step
module affra_cell import affra_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          first,
    input  cell_op_t      op,
    input  cell_bcast_t   bc,
    input  seg_t          left_seg,
    input  seg_t          right_seg,
    output seg_t          seg,
    output cell_flags_t   flags,
    output logic [AW-1:0] al_out,
    output logic [AW-1:0] ae_out
);

    seg_t          seg_reg, seg_next;
    logic [AW:0]   al_reg, al_next;
    logic [AW-1:0] ae_reg;
    cell_flags_t   flags_reg, flags_next;
    logic [AW:0]   al_sum;
    logic [AW+1:0] ae_full;

    always_comb begin
        al_sum  = {1'b0, seg_reg.lo} + {1'b0, bc.amask};
        al_next = al_sum & ~{1'b0, bc.amask};
        ae_full = {1'b0, al_reg} + {1'b0, bc.size_m1};

        flags_next.fit     = seg_reg.valid && !al_reg[AW] && (ae_full <= {2'b0, seg_reg.hi});
        flags_next.exact   = (ae_full[AW-1:0] == seg_reg.hi);
        flags_next.below   = seg_reg.valid && (seg_reg.hi < bc.fs);
        flags_next.overlap = seg_reg.valid && (seg_reg.lo <= bc.fe) && (seg_reg.hi >= bc.fs);
        flags_next.prev_match = seg_reg.valid
                             && (({1'b0, seg_reg.hi} + 1'b1) == {1'b0, bc.fs});
        flags_next.next_match = seg_reg.valid && (seg_reg.lo != '0)
                             && ((seg_reg.lo - 1'b1) == bc.fe);

        seg_next = seg_reg;
        unique case (op)
            OP_HOLD:       seg_next = seg_reg;
            OP_INIT: begin
                seg_next.valid = first;
                seg_next.lo    = '0;
                seg_next.hi    = first ? bc.last : '0;
            end
            OP_TAKE_RIGHT: seg_next = right_seg;
            OP_TAKE_LEFT:  seg_next = left_seg;
            OP_SHRINK:     seg_next.lo = ae_reg + 1'b1;
            OP_SET_START:  seg_next.lo = bc.fs;
            OP_SET_END:    seg_next.hi = bc.fe;
            OP_HI_RIGHT:   seg_next.hi = right_seg.hi;
            OP_LOAD: begin
                seg_next.valid = 1'b1;
                seg_next.lo    = bc.fs;
                seg_next.hi    = bc.fe;
            end
            default:       seg_next = seg_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg.valid <= first;
            seg_reg.lo    <= '0;
            seg_reg.hi    <= first ? '1 : '0;
        end else begin
            seg_reg <= seg_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (bc.do_align) begin
            al_reg <= al_next;
        end
        if (bc.do_eval) begin
            flags_reg <= flags_next;
            ae_reg    <= ae_full[AW-1:0];
        end
    end

    assign seg    = seg_reg;
    assign flags  = flags_reg;
    assign al_out = al_reg[AW-1:0];
    assign ae_out = ae_reg;

endmodule

@@ hw/rtl/aligned_first_fit_range_allocator_top.sv @@
// an accepted word goes through the align, fit check and apply steps; its result word
// is registered in the apply step; no new word is accepted until apply is done (accept, align, fit check, apply)
// the apply step waits while an earlier result word is still not taken
// every cell checks its own segment in parallel; the table shifts one cell a step
// reset (aresetn, synchronous, active low) and any total_size write leave one
// free segment covering the whole space; reset space is 2^32 units
`include "assert_macros.svh"
module aligned_first_fit_range_allocator_top import affra_pkg::*; #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic          aclk,
    input  logic          aresetn,
    // configuration
    input  logic          cfg_wr_en,
    input  logic [SW-1:0] cfg_wr_data,
    // request words
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          s_mode,
    input  logic [SW-1:0] s_request_size,
    input  logic [LW-1:0] s_align_log2,
    input  logic [AW-1:0] s_free_start,
    input  logic [AW-1:0] s_free_end,
    // result words
    output logic          m_valid,
    input  logic          m_ready,
    output logic [1:0]    m_status,
    output logic [AW-1:0] m_align_start,
    output logic [AW-1:0] m_block_start,
    output logic [AW-1:0] m_block_end
);

    localparam int N = MAX_SEGMENTS;

    // sequencer codes
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ALIGN = 2'd1;
    localparam logic [1:0] S_FIT   = 2'd2;
    localparam logic [1:0] S_APPLY = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] last_reg, last_next;
    logic [SW-1:0] cfg_last;

    // captured request word
    logic          mode_reg;
    logic [SW-1:0] size_reg;
    logic [LW-1:0] align_reg;
    logic [AW-1:0] fs_reg, fe_reg;

    // result register
    logic          m_valid_reg, m_valid_next;
    logic [1:0]    status_reg, status_next;
    logic [AW-1:0] al_res_reg, al_res_next;
    logic [AW-1:0] bs_res_reg, bs_res_next;
    logic [AW-1:0] be_res_reg, be_res_next;

    cell_bcast_t   bc;
    cell_op_t      op_v [N];
    seg_t          seg_v [N];
    seg_t          left_v [N];
    seg_t          right_v [N];
    cell_flags_t   flags_v [N];
    logic [AW-1:0] al_v [N];
    logic [AW-1:0] ae_v [N];

    logic [N-1:0]  valid_v, fit_v, exact_v, below_v, over_v, pm_v, nm_v;
    logic [N-1:0]  win_oh, geq_win, last_below, ins_at, first_above, after_ins;
    logic [SW-1:0] size_m1;
    logic          accept, apply_fire, init_tbl;
    logic          alloc_ok, win_exact, free_bad, merge_prev, merge_next, tbl_full;

    assign accept     = s_valid && s_ready;
    assign s_ready    = (state_reg == S_IDLE);
    assign apply_fire = (state_reg == S_APPLY) && (!m_valid_reg || m_ready);
    assign init_tbl   = cfg_wr_en;

    // zero acts as one, sizes above the space saturate
    assign cfg_last  = (cfg_wr_data == '0) ? '0 : cfg_wr_data - 1'b1;
    assign last_next = cfg_last[SW-1] ? '1 : cfg_last[AW-1:0];

    assign size_m1 = size_reg - 1'b1;

    always_comb begin
        bc.do_align = (state_reg == S_ALIGN);
        bc.do_eval  = (state_reg == S_FIT);
        bc.amask    = ({{(AW-1){1'b0}}, 1'b1} << align_reg) - 1'b1;
        bc.size_m1  = size_m1;
        bc.fs       = fs_reg;
        bc.fe       = fe_reg;
        bc.last     = cfg_wr_en ? last_next : last_reg;
    end

    // the chain of segment cells
    for (genvar g = 0; g < N; g++) begin : g_cell
        if (g == 0) begin : g_l0
            assign left_v[g] = '0;
        end else begin : g_l
            assign left_v[g] = seg_v[g-1];
        end
        if (g == N-1) begin : g_rn
            assign right_v[g] = '0;
        end else begin : g_r
            assign right_v[g] = seg_v[g+1];
        end

        affra_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .first     (g == 0),
            .op        (op_v[g]),
            .bc        (bc),
            .left_seg  (left_v[g]),
            .right_seg (right_v[g]),
            .seg       (seg_v[g]),
            .flags     (flags_v[g]),
            .al_out    (al_v[g]),
            .ae_out    (ae_v[g])
        );

        assign valid_v[g] = seg_v[g].valid;
        assign fit_v[g]   = flags_v[g].fit;
        assign exact_v[g] = flags_v[g].exact;
        assign below_v[g] = flags_v[g].below;
        assign over_v[g]  = flags_v[g].overlap;
        assign pm_v[g]    = flags_v[g].prev_match;
        assign nm_v[g]    = flags_v[g].next_match;
    end

    // lowest fitting cell, and it with all cells above it
    assign win_oh  = fit_v & (~fit_v + 1'b1);
    assign geq_win = ~(win_oh - 1'b1);

    // below_v is a run of ones from cell 0: the free block goes at its end
    assign last_below  = below_v & ~(below_v >> 1);
    assign ins_at      = ~below_v & {below_v[N-2:0], 1'b1};
    assign first_above = ins_at & valid_v;
    assign after_ins   = ~{below_v[N-2:0], 1'b1};

    assign alloc_ok   = !((size_reg == '0) || (size_m1 > {1'b0, last_reg})) && (|fit_v);
    assign win_exact  = |(win_oh & exact_v);
    assign free_bad   = (fs_reg > fe_reg) || (fe_reg > last_reg) || (|over_v);
    assign merge_prev = |(last_below & pm_v);
    assign merge_next = |(first_above & nm_v);
    assign tbl_full   = valid_v[N-1];

    // per-cell step of the table update
    always_comb begin
        for (int i = 0; i < N; i++) begin
            op_v[i] = OP_HOLD;
            if (init_tbl) begin
                op_v[i] = OP_INIT;
            end else if (apply_fire && mode_reg == MODE_ALLOC && alloc_ok) begin
                if (win_oh[i] && !win_exact) begin
                    op_v[i] = OP_SHRINK;
                end else if (geq_win[i] && win_exact) begin
                    op_v[i] = OP_TAKE_RIGHT;
                end
            end else if (apply_fire && mode_reg == MODE_FREE && !free_bad) begin
                if (merge_prev && merge_next) begin
                    if (last_below[i]) begin
                        op_v[i] = OP_HI_RIGHT;
                    end else if (!below_v[i]) begin
                        op_v[i] = OP_TAKE_RIGHT;
                    end
                end else if (merge_prev) begin
                    if (last_below[i]) begin
                        op_v[i] = OP_SET_END;
                    end
                end else if (merge_next) begin
                    if (first_above[i]) begin
                        op_v[i] = OP_SET_START;
                    end
                end else if (!tbl_full) begin
                    if (ins_at[i]) begin
                        op_v[i] = OP_LOAD;
                    end else if (after_ins[i]) begin
                        op_v[i] = OP_TAKE_LEFT;
                    end
                end
            end
        end
    end

    // result word
    always_comb begin
        al_res_next = '0;
        bs_res_next = '0;
        be_res_next = '0;
        status_next = ST_OK;
        if (mode_reg == MODE_ALLOC) begin
            if (alloc_ok) begin
                for (int i = 0; i < N; i++) begin
                    al_res_next = al_res_next | (al_v[i] & {AW{win_oh[i]}});
                    bs_res_next = bs_res_next | (seg_v[i].lo & {AW{win_oh[i]}});
                    be_res_next = be_res_next | (ae_v[i] & {AW{win_oh[i]}});
                end
            end else begin
                status_next = ST_NOFIT;
            end
        end else begin
            if (free_bad) begin
                status_next = ST_NOFIT;
            end else if (!merge_prev && !merge_next && tbl_full) begin
                status_next = ST_FULL;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) begin
                state_next = S_ALIGN;
            end
            S_ALIGN: state_next = S_FIT;
            S_FIT:   state_next = S_APPLY;
            S_APPLY: if (apply_fire) begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (apply_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            last_reg    <= '1;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                last_reg <= last_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg  <= s_mode;
            size_reg  <= s_request_size;
            align_reg <= s_align_log2;
            fs_reg    <= s_free_start;
            fe_reg    <= s_free_end;
        end
        if (apply_fire) begin
            status_reg <= status_next;
            al_res_reg <= al_res_next;
            bs_res_reg <= bs_res_next;
            be_res_reg <= be_res_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_align_start = al_res_reg;
    assign m_block_start = bs_res_reg;
    assign m_block_end   = be_res_reg;

    // live segments always fill the chain from cell 0 with no holes
    `AFFRA_ASSERT_IMPL(a_valid_prefix, aclk, aresetn, 1'b1, ((valid_v + 1'b1) & valid_v) == '0)
    // at most one cell wins an allocation
    `AFFRA_ASSERT_IMPL(a_win_onehot, aclk, aresetn, state_reg == S_APPLY, $onehot0(win_oh))
    // an accepted word always enters the align step
    `AFFRA_ASSERT_NEXT(a_accept_align, aclk, aresetn, accept, state_reg == S_ALIGN)
    // a result word is loaded only from the apply step
    `AFFRA_ASSERT_NEXT(a_res_from_apply, aclk, aresetn, apply_fire, m_valid && state_reg == S_IDLE)

endmodule
